@@ rtl/core/hmbs_pkg.sv @@
// shared types and constants for the heightmap bilinear sampler
// no dependencies
`timescale 1ns / 1ps

package hmbs_pkg;

  localparam int MAX_SIDE_DEF  = 128;
  localparam int FRAC_BITS_DEF = 8;
  localparam int HEIGHT_W      = 32;
  localparam int COORD_W       = 24;
  localparam int SIDE_W        = 8;
  localparam int ACTION_W      = 2;
  localparam int SIDE_RESET    = 65;
  localparam int SIDE_MIN      = 2;

  localparam logic [ACTION_W-1:0] ACT_WRITE  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd2;

  typedef struct packed {
    logic feed;
    logic clr;
  } mac_ctl_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

@@ rtl/core/heightmap_bilinear_sampler.sv @@
// heightmap bilinear sampler top level: sequencer, config register, output regs
// depends on hmbs_pkg, hmbs_store, hmbs_mac
`timescale 1ns / 1ps

// usage:
// - an item is taken at a clock edge with start high and busy low; it carries
//   action_i (write, point read, bilinear sample), x_pos_i, z_pos_i, height_in_i
// - every item gives one result: height_out_o and in_range_o, shown for one
//   cycle with res_valid_o high; the receiver cannot stall, so it must take it
// - side_count is written over cfg_valid_i / cfg_ready_o / cfg_data_i; ready is
//   always high, write it only while busy is low and no result is pending
// - a write or point read goes through the prep, row, access and output states;
//   a sample makes four corner reads from the single-port height memory,
//   then six passes through the one shared multiply-accumulate unit
// - busy is high from accept until the result strobe, so one item is in work
//   at a time; the next item can be taken in the strobe cycle
// - after reset the memory is cleared one word per cycle, all MAX_SIDE*MAX_SIDE
//   words (16384 at the default), with busy high; config writes still go in

module heightmap_bilinear_sampler
  import hmbs_pkg::*;
#(
  parameter int MAX_SIDE  = MAX_SIDE_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [ACTION_W-1:0]        action_i,
  input  logic signed [COORD_W-1:0]  x_pos_i,
  input  logic signed [COORD_W-1:0]  z_pos_i,
  input  logic signed [HEIGHT_W-1:0] height_in_i,
  output logic                       res_valid_o,
  output logic signed [HEIGHT_W-1:0] height_out_o,
  output logic                       in_range_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [SIDE_W-1:0]          cfg_data_i
);

  localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
  localparam int AW       = $clog2(DEPTH);
  localparam int CW       = $clog2(MAX_SIDE);
  localparam int SW       = $clog2(MAX_SIDE + 1);
  localparam int EW       = (SW > SIDE_W) ? SW : SIDE_W;
  localparam int CMPW     = (((SW + FRAC_BITS) > COORD_W) ? (SW + FRAC_BITS) : COORD_W) + 1;
  localparam int HW       = HEIGHT_W + FRAC_BITS + 1;
  localparam int ACCW     = HW + FRAC_BITS + 1;
  localparam int SIDE_RST = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_PREP, ST_ROW, ST_RW, ST_RWO,
    ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_RD4, ST_W1, ST_V0, ST_V1, ST_W2, ST_DONE
  } state_e;

  state_e                       state_q;
  logic [AW-1:0]                clr_addr_q;
  logic [SW-1:0]                side_q;
  logic [ACTION_W-1:0]          act_q;
  logic signed [COORD_W-1:0]    x_q;
  logic signed [COORD_W-1:0]    z_q;
  logic [HEIGHT_W-1:0]          hin_q;
  logic [CW-1:0]                x0_q, x1_q, z0_q, z1_q;
  logic [FRAC_BITS-1:0]         fx_q, fz_q;
  logic                         ok_q;
  logic [AW-1:0]                row0_q, row1_q;
  logic signed [HW-1:0]         h0_q;
  logic                         res_valid_q;
  logic signed [HEIGHT_W-1:0]   height_out_q;
  logic                         in_range_q;

  // config clamp
  logic [EW-1:0]                cfg_ext;
  logic [SW-1:0]                cfg_side;

  // item preparation
  logic signed [CMPW-1:0]       xs, zs, xf, zf, side_s, hi_s, cx, cz;
  logic [SW-1:0]                side_m1;
  logic                         ok_x, ok_z;
  logic [CW-1:0]                p_x0, p_z0, p_x1, p_z1;
  logic [CW:0]                  x0p1, z0p1;
  logic [CW+SW-1:0]             row_prod;

  // memory and mac
  mem_ctl_t                     mem_ctl;
  logic [AW-1:0]                mem_addr;
  logic [HEIGHT_W-1:0]          mem_wdata;
  logic [HEIGHT_W-1:0]          mem_rdata;
  logic signed [HW-1:0]         rd_ext;
  mac_ctl_t                     mac_ctl;
  logic signed [HW-1:0]         mac_a;
  logic [FRAC_BITS:0]           mac_w;
  logic [FRAC_BITS:0]           w_one;
  logic signed [ACCW-1:0]       acc;

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != ST_IDLE);

  always_comb begin
    cfg_ext = EW'(cfg_data_i);
    if (cfg_data_i < SIDE_W'(SIDE_MIN)) begin
      cfg_side = SW'(SIDE_MIN);
    end else if (cfg_ext > EW'(MAX_SIDE)) begin
      cfg_side = SW'(MAX_SIDE);
    end else begin
      cfg_side = SW'(cfg_data_i);
    end
  end

  always_comb begin
    xs      = {{(CMPW-COORD_W){x_q[COORD_W-1]}}, x_q};
    zs      = {{(CMPW-COORD_W){z_q[COORD_W-1]}}, z_q};
    xf      = xs >>> FRAC_BITS;
    zf      = zs >>> FRAC_BITS;
    side_m1 = side_q - SW'(1);
    side_s  = {{(CMPW-SW){1'b0}}, side_q};
    hi_s    = {{(CMPW-SW-FRAC_BITS){1'b0}}, side_m1, {FRAC_BITS{1'b0}}};
    ok_x    = !xf[CMPW-1] && (xf < side_s);
    ok_z    = !zf[CMPW-1] && (zf < side_s);
    cx      = xs[CMPW-1] ? '0 : ((xs > hi_s) ? hi_s : xs);
    cz      = zs[CMPW-1] ? '0 : ((zs > hi_s) ? hi_s : zs);
    if (act_q == ACT_SAMPLE) begin
      p_x0 = cx[FRAC_BITS +: CW];
      p_z0 = cz[FRAC_BITS +: CW];
    end else begin
      p_x0 = xf[CW-1:0];
      p_z0 = zf[CW-1:0];
    end
    x0p1 = (CW+1)'(p_x0) + (CW+1)'(1);
    z0p1 = (CW+1)'(p_z0) + (CW+1)'(1);
    p_x1 = (x0p1 < (CW+1)'(side_m1)) ? x0p1[CW-1:0] : side_m1[CW-1:0];
    p_z1 = (z0p1 < (CW+1)'(side_m1)) ? z0p1[CW-1:0] : side_m1[CW-1:0];
  end

  assign row_prod = z0_q * side_q;

  // memory port
  always_comb begin
    mem_ctl   = '0;
    mem_addr  = row0_q + AW'(x0_q);
    mem_wdata = hin_q;
    unique case (state_q)
      ST_CLEAR: begin
        mem_ctl.we = 1'b1;
        mem_addr   = clr_addr_q;
        mem_wdata  = '0;
      end
      ST_RW: begin
        mem_ctl.we = ok_q && (act_q == ACT_WRITE);
        mem_ctl.re = ok_q && (act_q == ACT_READ);
      end
      ST_RD0: begin
        mem_ctl.re = 1'b1;
      end
      ST_RD1: begin
        mem_ctl.re = 1'b1;
        mem_addr   = row0_q + AW'(x1_q);
      end
      ST_RD2: begin
        mem_ctl.re = 1'b1;
        mem_addr   = row1_q + AW'(x0_q);
      end
      ST_RD3: begin
        mem_ctl.re = 1'b1;
        mem_addr   = row1_q + AW'(x1_q);
      end
      default: begin
        mem_ctl = '0;
      end
    endcase
  end

  // mac feed
  assign rd_ext = {{(HW-HEIGHT_W){mem_rdata[HEIGHT_W-1]}}, mem_rdata};
  assign w_one  = {1'b1, {FRAC_BITS{1'b0}}};

  always_comb begin
    mac_ctl = '0;
    mac_a   = rd_ext;
    mac_w   = w_one - {1'b0, fx_q};
    unique case (state_q)
      ST_RD1: begin
        mac_ctl = '{feed: 1'b1, clr: 1'b1};
      end
      ST_RD2: begin
        mac_ctl.feed = 1'b1;
        mac_w        = {1'b0, fx_q};
      end
      ST_RD3: begin
        mac_ctl = '{feed: 1'b1, clr: 1'b1};
      end
      ST_RD4: begin
        mac_ctl.feed = 1'b1;
        mac_w        = {1'b0, fx_q};
      end
      ST_V0: begin
        mac_ctl = '{feed: 1'b1, clr: 1'b1};
        mac_a   = h0_q;
        mac_w   = w_one - {1'b0, fz_q};
      end
      ST_V1: begin
        mac_ctl.feed = 1'b1;
        mac_a        = acc[HW-1:0];
        mac_w        = {1'b0, fz_q};
      end
      default: begin
        mac_ctl = '0;
      end
    endcase
  end

  hmbs_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  hmbs_mac #(
    .FRAC_BITS (FRAC_BITS),
    .AW_A      (HW),
    .ACCW      (ACCW)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (mac_a),
    .w_i    (mac_w),
    .acc_o  (acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_addr_q   <= '0;
      side_q       <= SW'(SIDE_RST);
      res_valid_q  <= 1'b0;
      height_out_q <= '0;
      in_range_q   <= 1'b0;
      act_q        <= ACT_WRITE;
      x_q          <= '0;
      z_q          <= '0;
      hin_q        <= '0;
      x0_q         <= '0;
      x1_q         <= '0;
      z0_q         <= '0;
      z1_q         <= '0;
      fx_q         <= '0;
      fz_q         <= '0;
      ok_q         <= 1'b0;
      row0_q       <= '0;
      row1_q       <= '0;
      h0_q         <= '0;
    end else begin
      res_valid_q <= 1'b0;
      if (cfg_valid_i) begin
        side_q <= cfg_side;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + AW'(1);
          if (clr_addr_q == AW'(DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            act_q   <= action_i;
            x_q     <= x_pos_i;
            z_q     <= z_pos_i;
            hin_q   <= height_in_i;
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          x0_q    <= p_x0;
          z0_q    <= p_z0;
          x1_q    <= p_x1;
          z1_q    <= p_z1;
          fx_q    <= cx[FRAC_BITS-1:0];
          fz_q    <= cz[FRAC_BITS-1:0];
          ok_q    <= ok_x && ok_z && ((act_q == ACT_WRITE) || (act_q == ACT_READ));
          state_q <= ST_ROW;
        end
        ST_ROW: begin
          row0_q  <= row_prod[AW-1:0];
          state_q <= (act_q == ACT_SAMPLE) ? ST_RD0 : ST_RW;
        end
        ST_RW: begin
          state_q <= ST_RWO;
        end
        ST_RWO: begin
          res_valid_q  <= 1'b1;
          height_out_q <= (ok_q && (act_q == ACT_READ)) ? mem_rdata : '0;
          in_range_q   <= ok_q;
          state_q      <= ST_IDLE;
        end
        ST_RD0: begin
          row1_q  <= (z1_q != z0_q) ? (row0_q + AW'(side_q)) : row0_q;
          state_q <= ST_RD1;
        end
        ST_RD1: begin
          state_q <= ST_RD2;
        end
        ST_RD2: begin
          state_q <= ST_RD3;
        end
        ST_RD3: begin
          state_q <= ST_RD4;
        end
        ST_RD4: begin
          h0_q    <= acc[HW-1:0];
          state_q <= ST_W1;
        end
        ST_W1: begin
          state_q <= ST_V0;
        end
        ST_V0: begin
          state_q <= ST_V1;
        end
        ST_V1: begin
          state_q <= ST_W2;
        end
        ST_W2: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          res_valid_q  <= 1'b1;
          height_out_q <= acc[2*FRAC_BITS +: HEIGHT_W];
          in_range_q   <= 1'b1;
          state_q      <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_valid_o  = res_valid_q;
  assign height_out_o = height_out_q;
  assign in_range_o   = in_range_q;

endmodule

@@ rtl/core/hmbs_store.sv @@
// single-port height memory with registered read data
// depends on hmbs_pkg
`timescale 1ns / 1ps

module hmbs_store
  import hmbs_pkg::*;
#(
  parameter int DEPTH = MAX_SIDE_DEF * MAX_SIDE_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  mem_ctl_t            ctl_i,
  input  logic [AW-1:0]       addr_i,
  input  logic [HEIGHT_W-1:0] wdata_i,
  output logic [HEIGHT_W-1:0] rdata_o
);

  logic [HEIGHT_W-1:0] mem [DEPTH];
  logic [HEIGHT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[addr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/hmbs_mac.sv @@
// shared multiply-accumulate unit: registered product, then accumulator
// depends on hmbs_pkg
`timescale 1ns / 1ps

module hmbs_mac
  import hmbs_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int AW_A      = HEIGHT_W + FRAC_BITS + 1,
  parameter int ACCW      = AW_A + FRAC_BITS + 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mac_ctl_t               ctl_i,
  input  logic signed [AW_A-1:0] a_i,
  input  logic [FRAC_BITS:0]     w_i,
  output logic signed [ACCW-1:0] acc_o
);

  localparam int PW = AW_A + FRAC_BITS + 2;

  logic signed [PW-1:0]     prod_full;
  logic signed [ACCW-1:0]   prod_q;
  logic                     v1_q;
  logic                     clr1_q;
  logic signed [ACCW-1:0]   acc_q;

  assign prod_full = a_i * $signed({1'b0, w_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      clr1_q <= 1'b0;
    end else begin
      v1_q   <= ctl_i.feed;
      clr1_q <= ctl_i.clr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.feed) begin
      prod_q <= prod_full[ACCW-1:0];
    end
    if (v1_q) begin
      acc_q <= (clr1_q ? '0 : acc_q) + prod_q;
    end
  end

  assign acc_o = acc_q;

endmodule

@@ tb/tb_heightmap_bilinear_sampler.sv @@
// self-checking testbench for heightmap_bilinear_sampler: writes, point reads and
// bilinear samples over several side_count settings, checked against a predictor
// depends on hmbs_pkg and heightmap_bilinear_sampler
`timescale 1ns / 1ps

module tb_heightmap_bilinear_sampler;
  import hmbs_pkg::*;

  localparam int FRAC      = FRAC_BITS_DEF;
  localparam int ONE       = 1 << FRAC;
  localparam int MAX_CELLS = MAX_SIDE_DEF * MAX_SIDE_DEF;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    logic signed [HEIGHT_W-1:0] height;
    logic                       in_range;
  } hm_result_t;

  class sampler_scoreboard;
    int                heights [MAX_CELLS];
    logic [SIDE_W-1:0] side_reg;
    hm_result_t        expected_q [$];
    int                fail_count;

    function new();
      side_reg   = SIDE_W'(SIDE_RESET);
      fail_count = 0;
      foreach (heights[i]) heights[i] = 0;
    endfunction

    function int eff_side();
      int s;
      s = int'(side_reg);
      if (s < SIDE_MIN) s = SIDE_MIN;
      if (s > MAX_SIDE_DEF) s = MAX_SIDE_DEF;
      return s;
    endfunction

    function void note_item(logic [ACTION_W-1:0] act, logic signed [COORD_W-1:0] x,
                            logic signed [COORD_W-1:0] z, logic signed [HEIGHT_W-1:0] h);
      int s, xi, zi, xf, zf, lim, cx, cz, x0, z0, x1, z1, fx, fz;
      longint c00, c10, c01, c11, h0, h1, acc;
      hm_result_t r;
      s = eff_side();
      xi = int'(x);
      zi = int'(z);
      r.height   = '0;
      r.in_range = 1'b0;
      case (act)
        ACT_WRITE, ACT_READ: begin
          xf = xi >>> FRAC;
          zf = zi >>> FRAC;
          if (xf >= 0 && xf < s && zf >= 0 && zf < s) begin
            r.in_range = 1'b1;
            if (act == ACT_WRITE) heights[zf * s + xf] = h;
            else r.height = heights[zf * s + xf];
          end
        end
        ACT_SAMPLE: begin
          lim = (s - 1) * ONE;
          cx = (xi < 0) ? 0 : ((xi > lim) ? lim : xi);
          cz = (zi < 0) ? 0 : ((zi > lim) ? lim : zi);
          x0 = cx >> FRAC;
          z0 = cz >> FRAC;
          fx = cx & (ONE - 1);
          fz = cz & (ONE - 1);
          x1 = (x0 + 1 < s - 1) ? x0 + 1 : s - 1;
          z1 = (z0 + 1 < s - 1) ? z0 + 1 : s - 1;
          c00 = longint'(heights[z0 * s + x0]);
          c10 = longint'(heights[z0 * s + x1]);
          c01 = longint'(heights[z1 * s + x0]);
          c11 = longint'(heights[z1 * s + x1]);
          h0  = c00 * (ONE - fx) + c10 * fx;
          h1  = c01 * (ONE - fx) + c11 * fx;
          acc = h0 * (ONE - fz) + h1 * fz;
          r.height   = HEIGHT_W'(acc >>> (2 * FRAC));
          r.in_range = 1'b1;
        end
        default: ;
      endcase
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_result(logic signed [HEIGHT_W-1:0] h, logic rng);
      hm_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result with no item pending, height_out %0d in_range %0b", $time, h, rng);
        fail_count++;
        return;
      end
      e = expected_q.pop_front();
      if (h !== e.height) begin
        $display("%0t: height_out expected %0d actual %0d", $time, e.height, h);
        fail_count++;
      end
      if (rng !== e.in_range) begin
        $display("%0t: in_range expected %0b actual %0b", $time, e.in_range, rng);
        fail_count++;
      end
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  logic [ACTION_W-1:0]        action_i;
  logic signed [COORD_W-1:0]  x_pos_i;
  logic signed [COORD_W-1:0]  z_pos_i;
  logic signed [HEIGHT_W-1:0] height_in_i;
  logic                       res_valid_o;
  logic signed [HEIGHT_W-1:0] height_out_o;
  logic                       in_range_o;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [SIDE_W-1:0]          cfg_data_i;

  sampler_scoreboard sb = new();
  bit no_idle = 1'b0;

  heightmap_bilinear_sampler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .action_i    (action_i),
    .x_pos_i     (x_pos_i),
    .z_pos_i     (z_pos_i),
    .height_in_i (height_in_i),
    .res_valid_o (res_valid_o),
    .height_out_o(height_out_o),
    .in_range_o  (in_range_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) sb.check_result(height_out_o, in_range_o);
  end

  task automatic send_item(logic [ACTION_W-1:0] act, int x, int z,
                           logic signed [HEIGHT_W-1:0] h);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    action_i    <= act;
    x_pos_i     <= x[COORD_W-1:0];
    z_pos_i     <= z[COORD_W-1:0];
    height_in_i <= h;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_item(act, x[COORD_W-1:0], z[COORD_W-1:0], h);
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_side(logic [SIDE_W-1:0] v);
    wait_drain();
    while (busy) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.side_reg = v;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int pick_coord(int s);
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, s * ONE - 1);
    if (r < 70) return (s - 1) * ONE + $urandom_range(0, 2 * ONE - 1);
    if (r < 80) return -int'($urandom_range(1, 4 * ONE));
    return int'($urandom);
  endfunction

  function automatic logic signed [HEIGHT_W-1:0] pick_height();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'sh7fffffff;
    if (r == 1) return 32'sh80000000;
    return $urandom;
  endfunction

  initial begin
    int phase_sides [8];
    int hot_x [8];
    int hot_z [8];
    int hot_n, hot_w, s, r, k, x, z;
    logic [ACTION_W-1:0] act;
    phase_sides = '{0, 255, 2, 128, 1, 65, 100, 200};
    hot_n = 0;
    hot_w = 0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    action_i    = ACT_WRITE;
    x_pos_i     = '0;
    z_pos_i     = '0;
    height_in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset side of 65: grid indexes 0..64
    send_item(ACT_WRITE, 0, 0, 32'sh7fffffff);
    send_item(ACT_WRITE, 64 * ONE + 255, 64 * ONE + 255, 32'sh80000000);
    send_item(ACT_WRITE, ONE, 0, 32'sh12345678);
    send_item(ACT_WRITE, 0, ONE, -1000000);
    send_item(ACT_WRITE, -1, 0, 32'sh0badcafe);
    send_item(ACT_WRITE, 65 * ONE, 0, 32'sh0badcafe);
    send_item(ACT_WRITE, -8388608, 8388607, 32'sh0badcafe);
    send_item(ACT_READ, 0, 0, 0);
    send_item(ACT_READ, 64 * ONE + 255, 64 * ONE + 255, 0);
    send_item(ACT_READ, -1, -1, 0);
    send_item(ACT_READ, -8388608, -8388608, 0);
    send_item(ACT_READ, 8388607, 8388607, 0);
    send_item(ACT_UNUSED, 0, 0, 32'sh55aa55aa);
    send_item(ACT_READ, 0, 0, 0);
    send_item(ACT_SAMPLE, ONE / 2, ONE / 2, 0);
    send_item(ACT_SAMPLE, 0, 0, 0);
    send_item(ACT_SAMPLE, -8388608, -8388608, 0);
    send_item(ACT_SAMPLE, 8388607, 8388607, 0);
    send_item(ACT_SAMPLE, 64 * ONE, 0, 0);
    send_item(ACT_SAMPLE, 37, 250, 0);
    send_item(ACT_WRITE, 63 * ONE, 63 * ONE, 32'sh7fffffff);
    send_item(ACT_WRITE, 64 * ONE, 63 * ONE, 32'sh7fffffff);
    send_item(ACT_SAMPLE, 63 * ONE + 128, 63 * ONE + 200, 0);
    send_item(ACT_SAMPLE, 64 * ONE - 1, 64 * ONE - 1, 0);

    foreach (phase_sides[p]) begin
      write_side(SIDE_W'(phase_sides[p]));
      s = sb.eff_side();
      for (int i = 0; i < 160; i++) begin
        if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 59) == 0) wait_drain();
        r = $urandom_range(0, 99);
        act = (r < 35) ? ACT_WRITE : (r < 60) ? ACT_READ : (r < 95) ? ACT_SAMPLE : ACT_UNUSED;
        if (act != ACT_WRITE && hot_n > 0 && $urandom_range(0, 1) == 1) begin
          k = $urandom_range(0, hot_n - 1);
          x = hot_x[k];
          z = hot_z[k];
          if (act == ACT_SAMPLE) begin
            x = x - int'($urandom_range(0, ONE - 1));
            z = z - int'($urandom_range(0, ONE - 1));
          end
        end else begin
          x = pick_coord(s);
          z = pick_coord(s);
        end
        send_item(act, x, z, pick_height());
        if (act == ACT_WRITE) begin
          hot_x[hot_w] = x;
          hot_z[hot_w] = z;
          hot_w = (hot_w + 1) % 8;
          if (hot_n < 8) hot_n++;
        end
      end
    end

    no_idle = 1'b0;
    wait_drain();
    repeat (20) @(posedge clk_i);
    sb.fail_count += sb.expected_q.size();
    if (sb.fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/hmbs_pkg.sv
rtl/core/hmbs_store.sv
rtl/core/hmbs_mac.sv
rtl/core/heightmap_bilinear_sampler.sv
tb/tb_heightmap_bilinear_sampler.sv
